[sv/vdn_pkg.sv]
// shared constants for the vector direction normalizer
`default_nettype none
package vdn_pkg;
    localparam int SPEED_W     = 8;
    localparam int VEL_W       = 9;
    localparam int QBITS       = 8;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd25;
    localparam int QUEUE_DEPTH = 2;
endpackage
`default_nettype wire

[sv/vdn_front.sv]
// front pipeline: differences, magnitudes, squares and scaled right-hand side
`default_nettype none
module vdn_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [vdn_pkg::SPEED_W-1:0]  speed,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] from_x,
    input  wire logic signed [COORD_WIDTH-1:0] from_y,
    input  wire logic signed [COORD_WIDTH-1:0] to_x,
    input  wire logic signed [COORD_WIDTH-1:0] to_y,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output logic [3*(2*(COORD_WIDTH+1))+33+4-1:0] q_data
);
    import vdn_pkg::*;

    localparam int A   = COORD_WIDTH + 1;
    localparam int D   = 2 * A;
    localparam int SW  = D + 1;
    localparam int R1W = D + SPEED_W;
    localparam int RW  = D + 2 * SPEED_W;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 r1, r2, r3, r4;
    logic signed [A-1:0]  dx, dy;
    logic [A-1:0]         ax1_reg, ay1_reg;
    logic [D-1:0]         dx2_reg, dy2_reg;
    logic [SW-1:0]        sum3_reg, sum4_reg;
    logic [R1W-1:0]       rx3_reg, ry3_reg;
    logic [RW-1:0]        rx4_reg, ry4_reg;
    logic [SPEED_W-1:0]   sp1_reg, sp2_reg, sp3_reg;
    logic [1:0]           n1_reg, n2_reg, n3_reg, n4_reg;
    logic [1:0]           z3_reg, z4_reg;

    // ready chain, each stage moves when the next has room
    assign r4       = !v4_reg || q_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_stall = !r1;

    // exact differences one bit wider than the coordinates
    assign dx = $signed({to_x[COORD_WIDTH-1], to_x}) - $signed({from_x[COORD_WIDTH-1], from_x});
    assign dy = $signed({to_y[COORD_WIDTH-1], to_y}) - $signed({from_y[COORD_WIDTH-1], from_y});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        // magnitudes and signs
        if (r1)
        begin
            ax1_reg <= dx[A-1] ? A'(-dx) : A'(dx);
            ay1_reg <= dy[A-1] ? A'(-dy) : A'(dy);
            n1_reg  <= {dy[A-1], dx[A-1]};
            sp1_reg <= speed;
        end
        // squares
        if (r2)
        begin
            dx2_reg <= ax1_reg * ax1_reg;
            dy2_reg <= ay1_reg * ay1_reg;
            n2_reg  <= n1_reg;
            sp2_reg <= sp1_reg;
        end
        // sum and first speed product
        if (r3)
        begin
            sum3_reg <= SW'(dx2_reg) + SW'(dy2_reg);
            rx3_reg  <= R1W'(dx2_reg) * R1W'(sp2_reg);
            ry3_reg  <= R1W'(dy2_reg) * R1W'(sp2_reg);
            z3_reg   <= {dy2_reg == '0, dx2_reg == '0};
            n3_reg   <= n2_reg;
            sp3_reg  <= sp2_reg;
        end
        // second speed product
        if (r4)
        begin
            sum4_reg <= sum3_reg;
            rx4_reg  <= RW'(rx3_reg) * RW'(sp3_reg);
            ry4_reg  <= RW'(ry3_reg) * RW'(sp3_reg);
            z4_reg   <= z3_reg;
            n4_reg   <= n3_reg;
        end
    end

    assign q_valid = v4_reg;
    assign q_data  = {sum4_reg, rx4_reg, ry4_reg, z4_reg, n4_reg};
endmodule
`default_nettype wire

[sv/vdn_queue.sv]
// small item queue between front and back
`default_nettype none
module vdn_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);
    import vdn_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [IW-1:0]     wp_reg, rp_reg;
    logic [IW:0]       cnt_reg;
    logic              push, pop;

    assign wr_ready = cnt_reg != (IW+1)'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (IW+1)'(push) - (IW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

[sv/vdn_back.sv]
// back pipeline: one quotient bit per stage for both components, then output register
`default_nettype none
module vdn_back #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    output logic                         q_ready,
    input  wire logic [3*(2*(COORD_WIDTH+1))+33+4-1:0] q_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [vdn_pkg::VEL_W-1:0] vel_x,
    output logic signed [vdn_pkg::VEL_W-1:0] vel_y
);
    import vdn_pkg::*;

    localparam int D  = 2 * (COORD_WIDTH + 1);
    localparam int SW = D + 1;
    localparam int RW = D + 2 * SPEED_W;
    localparam int CW = SW + 2 * QBITS;
    localparam int PW = SW + QBITS;

    typedef struct packed {
        logic [SW-1:0]    sum;
        logic [RW-1:0]    rx;
        logic [RW-1:0]    ry;
        logic [CW-1:0]    sx;
        logic [CW-1:0]    sy;
        logic [PW-1:0]    px;
        logic [PW-1:0]    py;
        logic [QBITS-1:0] qx;
        logic [QBITS-1:0] qy;
        logic [1:0]       z;
        logic [1:0]       n;
    } srch_t;

    srch_t st_reg  [QBITS];
    srch_t st_next [QBITS];
    srch_t src     [QBITS];
    logic  v_reg   [QBITS];
    logic  vs      [QBITS];
    logic  rdy     [QBITS+1];
    logic  vo_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg;

    // one trial bit: candidate q*q*sum built from running q*q*sum and q*sum
    function automatic logic [CW+PW+QBITS:0] trial(
        input logic [CW-1:0] s, input logic [PW-1:0] p, input logic [SW-1:0] sum,
        input logic [RW-1:0] r, input logic z, input int b);
        logic [CW-1:0] cand;
        logic          take;
        cand = s + (CW'(p) << (b + 1)) + (CW'(sum) << (2 * b));
        take = !z && (cand <= CW'(r));
        return {take, take ? cand : s, take ? (p + (PW'(sum) << b)) : p, take ? QBITS'(0) : QBITS'(0)};
    endfunction

    // ready chain
    assign rdy[QBITS] = !vo_reg || !out_stall;
    assign q_ready    = rdy[0];

    genvar k;
    generate
        for (k = 0; k < QBITS; k++)
        begin : g_stage
            localparam int B = QBITS - 1 - k;
            logic [CW+PW+QBITS:0] tx, ty;

            assign rdy[k] = !v_reg[k] || rdy[k+1];

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    src[k]     = '0;
                    {src[k].sum, src[k].rx, src[k].ry, src[k].z, src[k].n} = q_data;
                    vs[k]      = q_valid;
                end
            end
            else
            begin : g_rest
                assign src[k] = st_reg[k-1];
                assign vs[k]  = v_reg[k-1];
            end

            assign tx = trial(src[k].sx, src[k].px, src[k].sum, src[k].rx, src[k].z[0], B);
            assign ty = trial(src[k].sy, src[k].py, src[k].sum, src[k].ry, src[k].z[1], B);

            // next stage contents
            always_comb
            begin
                st_next[k]    = src[k];
                st_next[k].sx = tx[CW+PW+QBITS-1 -: CW];
                st_next[k].px = tx[PW+QBITS-1 -: PW];
                st_next[k].sy = ty[CW+PW+QBITS-1 -: CW];
                st_next[k].py = ty[PW+QBITS-1 -: PW];
                st_next[k].qx = src[k].qx | (QBITS'(tx[CW+PW+QBITS]) << B);
                st_next[k].qy = src[k].qy | (QBITS'(ty[CW+PW+QBITS]) << B);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (rdy[k])
                    v_reg[k] <= vs[k];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k]) st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    // output register with sign applied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (rdy[QBITS])
            vo_reg <= v_reg[QBITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[QBITS])
        begin
            vx_reg <= st_reg[QBITS-1].n[0] ? -$signed({1'b0, st_reg[QBITS-1].qx})
                                           :  $signed({1'b0, st_reg[QBITS-1].qx});
            vy_reg <= st_reg[QBITS-1].n[1] ? -$signed({1'b0, st_reg[QBITS-1].qy})
                                           :  $signed({1'b0, st_reg[QBITS-1].qy});
        end
    end

    assign out_valid = vo_reg;
    assign vel_x     = vx_reg;
    assign vel_y     = vy_reg;
endmodule
`default_nettype wire

[sv/vector_direction_normalizer_core.sv]
// top level of the vector direction normalizer
//
//  channel  handshake           payload
//  in       in_valid/in_stall   from_x, from_y, to_x, to_y
//  out      out_valid/out_stall vel_x, vel_y
//  cfg      cfg_valid/cfg_ready cfg_data (speed)
//
// one item per cycle sustained while out_stall stays low; the path is
// 4 front stages, 1 queue slot, 8 quotient-bit stages and the output register
// reset sets speed to 25 and empties all stages; no clearing pass
// each side stalls on its own, the two-entry queue absorbs the difference
`default_nettype none
module vector_direction_normalizer_core #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vdn_pkg::SPEED_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] from_x,
    input  wire logic signed [COORD_WIDTH-1:0] from_y,
    input  wire logic signed [COORD_WIDTH-1:0] to_x,
    input  wire logic signed [COORD_WIDTH-1:0] to_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [vdn_pkg::VEL_W-1:0]   vel_x,
    output logic signed [vdn_pkg::VEL_W-1:0]   vel_y
);
    import vdn_pkg::*;

    localparam int QW = 3 * (2 * (COORD_WIDTH + 1)) + 33 + 4;

    logic [SPEED_W-1:0] speed_reg;
    logic               fq_valid, fq_ready, qb_valid, qb_ready;
    logic [QW-1:0]      fq_data, qb_data;

    // speed register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else if (cfg_valid)
            speed_reg <= cfg_data;
    end

    vdn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk, .rst_n, .speed(speed_reg), .in_valid, .in_stall,
        .from_x, .from_y, .to_x, .to_y,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    vdn_queue #(.DATA_W(QW)) u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    vdn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk, .rst_n,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .out_valid, .out_stall, .vel_x, .vel_y
    );
endmodule
`default_nettype wire
